>>> design/tcsp_pkg.sv
// Package for the tagged chunk stream parser: word types, command and
// result codes, parse phase codes, table sizes. No dependencies.
`default_nettype none
package tcsp_pkg;
  localparam int StartSlots = 8;
  localparam int ChunkSlots = 16;
  localparam int StartIdxW = $clog2(StartSlots);
  localparam int ChunkIdxW = $clog2(ChunkSlots);

  // Parse phases of the back part.
  localparam logic [1:0] PhSearch = 2'd0, PhId = 2'd1, PhSize = 2'd2, PhData = 2'd3;

  typedef enum logic [1:0] {
    CmdByte = 2'd0, CmdStart = 2'd1, CmdChunk = 2'd2, CmdNone = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KindData = 2'd0, KindEmpty = 2'd1, KindUnknown = 2'd2, KindOversize = 2'd3
  } kind_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  in_byte;
    logic [3:0]  slot_index;
    logic [31:0] entry_start_key;
    logic [31:0] entry_chunk_key;
    logic [31:0] entry_limit;
    logic        entry_enable;
  } in_word_t;

  typedef struct packed {
    logic [1:0] out_kind;
    logic [7:0] out_byte;
    logic       out_has_byte;
    logic [3:0] out_slot;
    logic       out_last;
  } out_word_t;
endpackage
`default_nettype wire

>>> design/tcsp_queue.sv
// Two-entry word queue between the front and the back part.
// Depends on tcsp_pkg.
`default_nettype none
module tcsp_queue import tcsp_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     wr_valid_i,
  output logic          wr_stall_o,
  input  wire in_word_t wr_word_i,
  output logic          rd_valid_o,
  input  wire logic     rd_take_i,
  output in_word_t      rd_word_o
);
  in_word_t   mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign wr_stall_o = cnt_q[1];
  assign rd_valid_o = cnt_q != 2'd0;
  assign rd_word_o  = mem_q[rp_q];
  assign push = wr_valid_i && !cnt_q[1];
  assign pop  = rd_take_i && rd_valid_o;

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= wr_word_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= !wp_q;
      if (pop) rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

>>> design/tcsp_back.sv
// Back part: slot tables, parse state machine and result register.
// Depends on tcsp_pkg. A rescan of three ID bytes runs one byte a cycle unless stalled.
`default_nettype none
module tcsp_back import tcsp_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     word_valid_i,
  input  wire in_word_t word_i,
  output logic          word_take_o,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output out_word_t     out_word_o
);
  logic [31:0] start_tab_q [StartSlots];
  logic [StartSlots-1:0] start_vld_q;
  logic [31:0] ck_start_q [ChunkSlots];
  logic [31:0] ck_chunk_q [ChunkSlots];
  logic [31:0] ck_lim_q [ChunkSlots];
  logic [ChunkSlots-1:0] ck_vld_q;

  logic [1:0]  ph_q, ph_d;
  logic [31:0] sw_q, sw_d, cw_q, cw_d, zw_q, zw_d, left_q, left_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [ChunkIdxW-1:0] slot_q, slot_d;
  // Rescan: remaining ID bytes held in resc_q, count in rn_q.
  logic [23:0] resc_q, resc_d;
  logic [1:0]  rn_q, rn_d;
  logic        ov_q, ov_d;
  out_word_t   ow_q, ow_d;

  logic        busy, ready, do_byte, rescan;
  logic [7:0]  b;
  logic [31:0] sw_new, cw_new, zw_new;
  logic        start_hit;
  logic        chunk_hit;
  logic [ChunkIdxW-1:0] hit_slot;

  assign rescan = rn_q != 2'd0;
  assign busy   = ov_q && out_stall_i;
  assign ready  = !busy && !rescan;
  assign word_take_o = ready && word_valid_i;
  assign out_valid_o = ov_q;
  assign out_word_o  = ow_q;
  assign do_byte = rescan ? !busy : (word_take_o && word_i.cmd == CmdByte);
  assign b = rescan ? resc_q[23:16] : word_i.in_byte;

  assign sw_new = {sw_q[23:0], b};
  assign cw_new = {cw_q[23:0], b};
  assign zw_new = {zw_q[23:0], b};

  always_comb begin
    start_hit = 1'b0;
    for (int i = 0; i < StartSlots; i++)
      if (start_vld_q[i] && start_tab_q[i] == sw_new) start_hit = 1'b1;
  end

  always_comb begin
    chunk_hit = 1'b0;
    hit_slot = '0;
    for (int i = ChunkSlots - 1; i >= 0; i--)
      if (ck_vld_q[i] && ck_start_q[i] == sw_q && ck_chunk_q[i] == cw_new) begin
        chunk_hit = 1'b1;
        hit_slot = ChunkIdxW'(i);
      end
  end

  always_comb begin
    ph_d = ph_q; sw_d = sw_q; cw_d = cw_q; zw_d = zw_q; left_d = left_q;
    cnt_d = cnt_q; slot_d = slot_q; resc_d = resc_q; rn_d = rn_q;
    ov_d = ov_q && out_stall_i;
    ow_d = ow_q;
    if (do_byte) begin
      if (rescan) begin
        resc_d = {resc_q[15:0], 8'd0};
        rn_d = rn_q - 2'd1;
      end
      unique case (ph_q)
        PhSearch: begin
          sw_d = sw_new;
          if (start_hit) begin
            cnt_d = 3'd0;
            ph_d = PhId;
          end
        end
        PhId: begin
          cw_d = cw_new;
          cnt_d = cnt_q + 3'd1;
          if (cnt_q == 3'd3 && rescan) begin
            // Cannot arise in a rescan of three bytes; kept for completeness.
            cnt_d = cnt_q + 3'd1;
          end else if (cnt_q == 3'd3) begin
            if (chunk_hit) begin
              slot_d = hit_slot;
              cnt_d = 3'd0;
              ph_d = PhSize;
            end else begin
              // The first ID byte re-enters the search window now; the
              // other three follow over the next cycles.
              sw_d = {24'd0, cw_q[23:16]};
              cw_d = '0; zw_d = '0; cnt_d = 3'd0;
              ph_d = PhSearch;
              resc_d = {cw_q[15:0], b};
              rn_d = 2'd3;
              ov_d = 1'b1;
              ow_d = '{out_kind: KindUnknown, out_byte: 8'd0, out_has_byte: 1'b0,
                       out_slot: 4'd0, out_last: 1'b0};
              for (int i = 0; i < StartSlots; i++)
                if (start_vld_q[i] && start_tab_q[i] == {24'd0, cw_q[23:16]})
                  ph_d = PhId;
            end
          end
        end
        PhSize: begin
          zw_d = zw_new;
          cnt_d = cnt_q + 3'd1;
          if (cnt_q == 3'd3) begin
            if (ck_lim_q[slot_q] != 32'd0 && zw_new > ck_lim_q[slot_q]) begin
              sw_d = '0; cw_d = '0; zw_d = '0; cnt_d = 3'd0; ph_d = PhSearch;
              ov_d = 1'b1;
              ow_d = '{out_kind: KindOversize, out_byte: 8'd0, out_has_byte: 1'b0,
                       out_slot: 4'(slot_q), out_last: 1'b0};
            end else if (zw_new == 32'd0) begin
              sw_d = '0; cw_d = '0; zw_d = '0; cnt_d = 3'd0; ph_d = PhSearch;
              ov_d = 1'b1;
              ow_d = '{out_kind: KindEmpty, out_byte: 8'd0, out_has_byte: 1'b0,
                       out_slot: 4'(slot_q), out_last: 1'b1};
            end else begin
              left_d = zw_new;
              ph_d = PhData;
            end
          end
        end
        default: begin
          ov_d = 1'b1;
          ow_d = '{out_kind: KindData, out_byte: b, out_has_byte: 1'b1,
                   out_slot: 4'(slot_q), out_last: left_q <= 32'd1};
          if (left_q <= 32'd1) begin
            left_d = '0;
            sw_d = '0; cw_d = '0; zw_d = '0; cnt_d = 3'd0; ph_d = PhSearch;
          end else begin
            left_d = left_q - 32'd1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (word_take_o && word_i.entry_enable) begin
      if (word_i.cmd == CmdStart && 32'(word_i.slot_index) < StartSlots)
        start_tab_q[StartIdxW'(word_i.slot_index)] <= word_i.entry_start_key;
      if (word_i.cmd == CmdChunk && 32'(word_i.slot_index) < ChunkSlots) begin
        ck_start_q[ChunkIdxW'(word_i.slot_index)] <= word_i.entry_start_key;
        ck_chunk_q[ChunkIdxW'(word_i.slot_index)] <= word_i.entry_chunk_key;
        ck_lim_q[ChunkIdxW'(word_i.slot_index)]   <= word_i.entry_limit;
      end
    end
    ow_q <= ow_d;
    resc_q <= resc_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_vld_q <= '0; ck_vld_q <= '0;
      ph_q <= PhSearch; sw_q <= '0; cw_q <= '0; zw_q <= '0; left_q <= '0;
      cnt_q <= '0; slot_q <= '0; rn_q <= '0; ov_q <= 1'b0;
    end else begin
      if (word_take_o && word_i.cmd == CmdStart && 32'(word_i.slot_index) < StartSlots)
        start_vld_q[StartIdxW'(word_i.slot_index)] <= word_i.entry_enable;
      if (word_take_o && word_i.cmd == CmdChunk && 32'(word_i.slot_index) < ChunkSlots)
        ck_vld_q[ChunkIdxW'(word_i.slot_index)] <= word_i.entry_enable;
      ph_q <= ph_d; sw_q <= sw_d; cw_q <= cw_d; zw_q <= zw_d; left_q <= left_d;
      cnt_q <= cnt_d; slot_q <= slot_d; rn_q <= rn_d; ov_q <= ov_d;
    end
  end
endmodule
`default_nettype wire

>>> design/tagged_chunk_stream_parser.sv
// Top level of the tagged chunk stream parser.
// Depends on tcsp_pkg, tcsp_queue and tcsp_back.
//
// Usage: input words (stream bytes and slot-table writes) enter on
// in_valid_i/in_stall_o with payload in_word_i. Result words leave on
// out_valid_o/out_stall_i with payload out_word_o. A word is moved at a
// rising edge where valid is high and stall is low.
// The front part is a two-entry queue that accepts a word every cycle while
// it has room. The back part takes one queued word per cycle while its result
// is not stalled and no rescan runs; out_valid_o for a stream byte's result
// (if any) rises in the cycle after the back part takes the byte.
// When an unknown chunk ID is dropped, the back part feeds the ID bytes back
// to the start ID search, the last three one at a time from its rescan
// register, and takes no new word meanwhile; apart from these rescans and
// output stalls, the sustained rate is one word per cycle.
// The back part holds a single result register; if the receiver stalls, the
// back part stops and the queue fills, then in_stall_o rises.
// Reset clears the queue, the parse state and all table valid bits; table
// contents are undefined until written.
`default_nettype none
module tagged_chunk_stream_parser import tcsp_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire in_word_t in_word_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output out_word_t     out_word_o
);
  logic     q_valid, q_take;
  in_word_t q_word;

  tcsp_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(in_valid_i), .wr_stall_o(in_stall_o), .wr_word_i(in_word_i),
    .rd_valid_o(q_valid), .rd_take_i(q_take), .rd_word_o(q_word)
  );

  tcsp_back u_back (
    .clk_i, .rst_ni,
    .word_valid_i(q_valid), .word_i(q_word), .word_take_o(q_take),
    .out_valid_o, .out_stall_i, .out_word_o
  );

  // A held result must not change while the receiver stalls.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("result changed under stall");

  // Payload words always carry a byte; other kinds never do.
  a_has_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.out_has_byte == (out_word_o.out_kind == KindData)))
    else $error("has_byte inconsistent with kind");

  // The back part takes nothing while its result is stalled.
  a_no_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> !q_take)
    else $error("word taken while stalled");
endmodule
`default_nettype wire

>>> tb/tagged_chunk_stream_parser_tb.sv
// Testbench for the tagged chunk stream parser: a directed table of words
// and a long random run of framed chunks, checked against a local predictor.
// Depends on tcsp_pkg and the tagged_chunk_stream_parser RTL.
`timescale 1ns / 1ps
module tagged_chunk_stream_parser_tb;
  import tcsp_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int RandomWords = 1700;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_word;

  tagged_chunk_stream_parser i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_word_o (out_word)
  );

  // The clock period is 20 ns: 10 ns high, then 10 ns low.
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // This is the predictor's copy of the parser state. The tables start at
  // zero. Their contents are only read through a valid bit, so a zero start
  // never changes a result.
  logic [1:0]  phase_q;
  logic [31:0] start_win_q, chunk_win_q, size_win_q, left_q;
  logic [2:0]  field_cnt_q;
  logic [3:0]  hit_slot_q;
  logic [31:0] start_key_q [StartSlots];
  logic        start_ok_q  [StartSlots];
  logic [31:0] ck_start_q  [ChunkSlots];
  logic [31:0] ck_id_q     [ChunkSlots];
  logic [31:0] ck_limit_q  [ChunkSlots];
  logic        ck_ok_q     [ChunkSlots];

  out_word_t expected_words[$];
  out_word_t last_pred;
  int pred_count;
  int errors, mismatches, cycles, got_words, unknown_drops;
  bit long_hold;

  function automatic out_word_t mk_result(kind_e k, logic [7:0] b, logic [3:0] s,
                                          logic l);
    out_word_t w;
    w.out_kind = k;
    w.out_byte = b;
    w.out_has_byte = (k == KindData);
    w.out_slot = s;
    w.out_last = l;
    return w;
  endfunction

  // Every predicted result goes through here, so the directed part can see
  // which word a step produced.
  task automatic queue_result(out_word_t r);
    expected_words.insert(expected_words.size(), r);
    last_pred = r;
    pred_count++;
  endtask

  task automatic restart_search();
    start_win_q = '0;
    chunk_win_q = '0;
    size_win_q = '0;
    field_cnt_q = '0;
    phase_q = PhSearch;
  endtask

  // This function shifts one header byte in. It returns 1 when the fourth byte
  // of the chunk ID has arrived.
  function automatic bit shift_header(logic [7:0] b);
    if (phase_q == PhSearch) begin
      start_win_q = {start_win_q[23:0], b};
      for (int i = 0; i < StartSlots; i++) begin
        if (start_ok_q[i] && start_key_q[i] == start_win_q) begin
          field_cnt_q = '0;
          phase_q = PhId;
          break;
        end
      end
      return 1'b0;
    end
    chunk_win_q = {chunk_win_q[23:0], b};
    field_cnt_q = field_cnt_q + 3'd1;
    return field_cnt_q == 3'd4;
  endfunction

  // This task advances the predictor by one accepted input word. It queues
  // the result that the word causes, if there is one.
  task automatic predict_parse(in_word_t w);
    logic [31:0] ids;
    int m;
    bit found;
    if (w.cmd == CmdStart) begin
      if (w.slot_index < StartSlots) begin
        if (w.entry_enable)
          start_key_q[w.slot_index[StartIdxW-1:0]] = w.entry_start_key;
        start_ok_q[w.slot_index[StartIdxW-1:0]] = w.entry_enable;
      end
    end else if (w.cmd == CmdChunk) begin
      if (w.entry_enable) begin
        ck_start_q[w.slot_index] = w.entry_start_key;
        ck_id_q[w.slot_index] = w.entry_chunk_key;
        ck_limit_q[w.slot_index] = w.entry_limit;
      end
      ck_ok_q[w.slot_index] = w.entry_enable;
    end else if (w.cmd == CmdByte) begin
      if (phase_q == PhSearch || phase_q == PhId) begin
        if (shift_header(w.in_byte)) begin
          found = 1'b0;
          for (int i = 0; i < ChunkSlots; i++) begin
            if (!found && ck_ok_q[i] && ck_start_q[i] == start_win_q &&
                ck_id_q[i] == chunk_win_q) begin
              found = 1'b1;
              hit_slot_q = i[3:0];
              field_cnt_q = '0;
              phase_q = PhSize;
            end
          end
          if (!found) begin
            // The chunk is unknown. The parser restarts and rescans the
            // four ID bytes, since a start ID may be hidden inside them.
            ids = chunk_win_q;
            restart_search();
            for (int i = 0; i < 4; i++) void'(shift_header(ids[31-8*i -: 8]));
            queue_result(mk_result(KindUnknown, 8'd0, 4'd0, 1'b0));
          end
        end
      end else if (phase_q == PhSize) begin
        m = int'(hit_slot_q);
        size_win_q = {size_win_q[23:0], w.in_byte};
        field_cnt_q = field_cnt_q + 3'd1;
        if (field_cnt_q == 3'd4) begin
          if (ck_limit_q[m] != 0 && size_win_q > ck_limit_q[m]) begin
            restart_search();
            queue_result(mk_result(KindOversize, 8'd0, hit_slot_q, 1'b0));
          end else if (size_win_q == 0) begin
            restart_search();
            queue_result(mk_result(KindEmpty, 8'd0, hit_slot_q, 1'b1));
          end else begin
            left_q = size_win_q;
            phase_q = PhData;
          end
        end
      end else begin
        queue_result(mk_result(KindData, w.in_byte, hit_slot_q, left_q <= 1));
        if (left_q <= 1) begin
          left_q = 0;
          restart_search();
        end else begin
          left_q = left_q - 1;
        end
      end
    end
  endtask

  // The sender drives each word at a falling edge and holds it until the
  // parser accepts it. Valid drops only during the random gap before a word.
  task automatic send_word(in_word_t w, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_word <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_parse(w);
    @(negedge clk);
  endtask

  function automatic in_word_t byte_word(logic [7:0] b);
    in_word_t w;
    logic [127:0] r;
    r = {$urandom, $urandom, $urandom, $urandom};
    w = in_word_t'(r[$bits(in_word_t)-1:0]);
    w.cmd = CmdByte;
    w.in_byte = b;
    return w;
  endfunction

  function automatic in_word_t table_word(cmd_e c, logic [3:0] s, logic [31:0] sk,
                                          logic [31:0] ck, logic [31:0] lim,
                                          logic en);
    in_word_t w;
    w.cmd = c;
    w.in_byte = 8'($urandom);
    w.slot_index = s;
    w.entry_start_key = sk;
    w.entry_chunk_key = ck;
    w.entry_limit = lim;
    w.entry_enable = en;
    return w;
  endfunction

  int gap_max;
  function automatic int pick_gap();
    return (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
  endfunction

  // This task sends a value as four bytes, big end first.
  task automatic send_be32(logic [31:0] v);
    for (int i = 0; i < 4; i++) send_word(byte_word(v[31-8*i -: 8]), pick_gap());
  endtask

  // The receiver waits a random number of cycles before each result. Once,
  // it holds off for a long stretch so that the parser fills up and stalls
  // its input.
  initial begin
    int hold_cnt;
    hold_cnt = 0;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) hold_cnt = pick_gap();
      @(negedge clk);
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (60) @(negedge clk);
        long_hold = 1'b0;
        out_stall <= 1'b0;
      end else if (hold_cnt > 0) begin
        out_stall <= 1'b1;
        hold_cnt--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // This block compares each accepted result with the oldest expected one.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      got_words++;
      if (out_word.out_kind == KindUnknown) unknown_drops++;
      if (expected_words.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("unexpected result word %p", out_word);
      end else begin
        out_word_t exp_w;
        exp_w = expected_words.pop_front();
        if (out_word !== exp_w) begin
          errors++;
          if (mismatches++ < 10)
            $display("result mismatch: expected %p, got %p", exp_w, out_word);
        end
      end
    end
  end

  // The watchdog ends a run that hangs.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  // The directed table. The keys are chosen so that every special case of
  // the parser is reached: unknown IDs with a hidden start ID, oversize, an
  // empty chunk, a write to an out-of-range slot, the unused command, and
  // all-ones and zero keys.
  typedef struct {
    in_word_t  w;
    bit        has_exp;
    out_word_t exp_w;
  } step_t;
  step_t steps[$];

  task automatic add_step(in_word_t w);
    step_t s;
    s.w = w;
    s.has_exp = 1'b0;
    steps.insert(steps.size(), s);
  endtask

  task automatic add_bytes(logic [31:0] v);
    for (int i = 0; i < 4; i++) add_step(byte_word(v[31-8*i -: 8]));
  endtask

  logic [31:0] keys [4];

  initial begin
    in_word_t w;
    int n;
    logic [31:0] sz;
    int s;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_word = '0;
    gap_max = 0;
    long_hold = 1'b0;
    errors = 0;
    mismatches = 0;
    cycles = 0;
    got_words = 0;
    unknown_drops = 0;
    pred_count = 0;
    last_pred = '0;
    restart_search();
    left_q = '0;
    hit_slot_q = '0;
    for (int i = 0; i < StartSlots; i++) begin
      start_key_q[i] = '0;
      start_ok_q[i] = 1'b0;
    end
    for (int i = 0; i < ChunkSlots; i++) begin
      ck_start_q[i] = '0;
      ck_id_q[i] = '0;
      ck_limit_q[i] = '0;
      ck_ok_q[i] = 1'b0;
    end
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // The directed part starts here.
    add_step(table_word(CmdStart, 4'd0, 32'hFFFF_FFFF, 32'h0, 32'h0, 1'b1));
    add_step(table_word(CmdStart, 4'd1, 32'h0000_00AB, 32'h0, 32'h0, 1'b1));
    add_step(table_word(CmdStart, 4'd15, 32'h1234_5678, 32'h0, 32'h0, 1'b1));
    add_step(table_word(CmdChunk, 4'd15, 32'hFFFF_FFFF, 32'h0000_0000,
                        32'hFFFF_FFFF, 1'b1));
    add_step(table_word(CmdChunk, 4'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd2, 1'b1));
    add_step(table_word(CmdNone, 4'd3, 32'h0, 32'h0, 32'h0, 1'b1));
    // An unknown ID whose first byte is a start ID: the drop is reported,
    // and the rescan takes the other three bytes as the first three of the next chunk ID.
    add_bytes(32'hFFFF_FFFF);
    add_bytes(32'hAB00_0001);
    steps[$].has_exp = 1'b1;
    steps[$].exp_w = mk_result(KindUnknown, 8'd0, 4'd0, 1'b0);
    add_step(byte_word(8'h02));
    steps[$].has_exp = 1'b1;
    steps[$].exp_w = mk_result(KindUnknown, 8'd0, 4'd0, 1'b0);
    add_bytes(32'hFFFF_FFFF);
    add_bytes(32'hFFFF_FFFF);
    add_bytes(32'h0000_0003);
    steps[$].has_exp = 1'b1;
    steps[$].exp_w = mk_result(KindOversize, 8'd0, 4'd0, 1'b0);
    add_bytes(32'hFFFF_FFFF);
    add_bytes(32'h0000_0000);
    add_bytes(32'h0000_0000);
    steps[$].has_exp = 1'b1;
    steps[$].exp_w = mk_result(KindEmpty, 8'd0, 4'd15, 1'b1);
    add_bytes(32'hFFFF_FFFF);
    add_bytes(32'h0000_0000);
    add_bytes(32'h0000_0002);
    add_step(byte_word(8'h00));
    add_step(byte_word(8'hFF));
    steps[$].has_exp = 1'b1;
    steps[$].exp_w = mk_result(KindData, 8'hFF, 4'd15, 1'b1);
    add_step(table_word(CmdChunk, 4'd15, 32'h0, 32'h0, 32'h0, 1'b0));
    add_step(table_word(CmdStart, 4'd0, 32'h0, 32'h0, 32'h0, 1'b0));
    foreach (steps[i]) begin
      n = pred_count;
      send_word(steps[i].w, 0);
      if (steps[i].has_exp &&
          (pred_count == n || last_pred !== steps[i].exp_w)) begin
        errors++;
        $display("directed step %0d: predictor disagrees with the table", i);
      end
    end

    // The random part follows. Most of it is well-formed chunks with random
    // content. The rest is noise, broken headers and table rewrites.
    for (int i = 0; i < 4; i++) keys[i] = $urandom;
    keys[0] = 32'h0;
    for (int i = 0; i < 4; i++)
      send_word(table_word(CmdStart, i[3:0], keys[i], 32'd0, 32'd0, 1'b1), 0);
    for (int i = 0; i < ChunkSlots; i++)
      send_word(table_word(CmdChunk, i[3:0], keys[i % 4], 32'(i * 7 + 1),
                           32'((i % 3 == 0) ? 0 : $urandom_range(1, 12)), 1'b1), 0);
    gap_max = 10;
    n = 0;
    while (n < RandomWords) begin
      if (n > RandomWords / 2 && n < RandomWords / 2 + 40) begin
        long_hold = 1'b1;
        n += 40;
      end
      case ($urandom_range(0, 9))
        0: begin
          w = byte_word(8'($urandom));
          send_word(w, pick_gap());
          n++;
        end
        1: begin
          w = table_word(cmd_e'($urandom_range(1, 3)), 4'($urandom),
                         $urandom_range(0, 3) == 0 ? $urandom : keys[$urandom_range(0, 3)],
                         32'($urandom_range(1, 20)), 32'($urandom_range(0, 12)),
                         1'($urandom));
          send_word(w, pick_gap());
          n++;
        end
        default: begin
          s = $urandom_range(0, ChunkSlots - 1);
          send_be32(keys[s % 4]);
          send_be32(32'(($urandom_range(0, 7) == 0) ? $urandom : (s * 7 + 1)));
          sz = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 14);
          send_be32(sz);
          n += 12;
          // Payload bytes may run shorter than the size; the following bytes are then
          // taken as payload. Bytes after a dropped chunk feed the start ID search.
          for (int k = 0; k < (sz > 16 ? 3 : sz); k++) begin
            send_word(byte_word(8'($urandom)), pick_gap());
            n++;
          end
        end
      endcase
    end

    // The run drains here. The testbench waits until every expected result has
    // arrived and then lets the clock run on before the summary.
    in_valid <= 1'b0;
    gap_max = 0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("%0d result words checked, %0d of them unknown-chunk drops;",
             got_words, unknown_drops);
    $display("framed chunks, noise, table rewrites and a long output hold-off.");
    if (errors == 0 && expected_words.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d errors", errors);
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

>>> filelist.f
design/tcsp_pkg.sv
design/tcsp_queue.sv
design/tcsp_back.sv
design/tagged_chunk_stream_parser.sv
tb/tagged_chunk_stream_parser_tb.sv
